// File: sv/maalu_pkg.sv
// ============================================================================
// maalu_pkg: shared types and constants of the modular accumulator ALU
// Residue width, command codes and the control bundles of the serial units.
// ============================================================================
`default_nettype none

package maalu_pkg;

    // Width of the modulus, the accumulator and every residue.
    localparam int RES_W = 31;

    // Number of double-and-add steps of one modular multiplication.
    localparam int MUL_STEPS = RES_W;

    // Modulus after reset.
    localparam logic [RES_W-1:0] MOD_RESET = 31'd1000000007;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_SUB  = 2'd2,
        CMD_MUL  = 2'd3
    } t_cmd;

    // Control of one bit-serial remainder unit.
    typedef struct packed {
        logic clear;
        logic step;
        logic din;
    } t_red_ctl;

    // Control of the bit-serial modular multiplier.
    typedef struct packed {
        logic start;
        logic step;
    } t_mul_ctl;

endpackage

`default_nettype wire

// File: sv/modular_accumulator_alu_top.sv
// ============================================================================
// modular_accumulator_alu_top: accumulator residue modulo a set modulus
// Loads, adds, subtracts or multiplies a signed operand into an accumulator
// held modulo m, and returns the new residue for every item.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_stall   i_cmd, i_operand
//  out       output     o_out_valid / i_out_stall o_residue
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_modulus
//
// An item is taken when valid is high and stall is low; a configuration
// write completes when valid and ready are both high (ready is always high).
// Each item runs through the bit-serial remainder pass over the operand and
// the accumulator, an adjust step, and then an ALU step or the 31-step
// serial modular multiplier before it is written out from the done state;
// one item is worked on at a time.
// Reset (synchronous, active low) clears the accumulator to zero, sets the
// modulus to 1000000007 and empties the output register.
// A finished residue waits in the output register while a stalled consumer
// holds it; the next item is accepted meanwhile and only its final write
// waits until the output register is free.
// ============================================================================
`default_nettype none

module modular_accumulator_alu_top
    import maalu_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [WORD_BITS-1:0] i_operand,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [RES_W-1:0]     o_residue,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [RES_W-1:0]     i_cfg_modulus
);

    // The serial pass runs over the wider of the operand word and the
    // accumulator, so both remainders are formed in the same pass.
    localparam int SER_BITS = (WORD_BITS > RES_W) ? WORD_BITS : RES_W;
    localparam int CNT_W    = $clog2(SER_BITS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_ADJ  = 6'b000100,
        S_ALU  = 6'b001000,
        S_MUL  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [RES_W-1:0]      r_cfg_mod;
    logic [RES_W-1:0]      r_mod;
    logic [RES_W-1:0]      r_acc;
    logic [SER_BITS-1:0]   r_acc_sh;
    logic [SER_BITS-1:0]   r_opd_sh;
    logic                  r_neg;
    t_cmd                  r_cmd;
    logic [RES_W-1:0]      r_op;
    logic [RES_W-1:0]      r_res;
    logic                  r_out_valid;
    logic [RES_W-1:0]      r_residue;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_finish;
    logic [WORD_BITS-1:0]  w_mag;
    logic [RES_W-1:0]      w_acc_rem;
    logic [RES_W-1:0]      w_opd_rem;
    logic [RES_W-1:0]      w_op_adj;
    logic [RES_W-1:0]      w_prod;
    logic [RES_W-1:0]      w_final;
    logic [RES_W:0]        w_add;
    logic [RES_W:0]        w_add_sub;
    logic [RES_W-1:0]      w_alu;
    t_red_ctl              w_acc_ctl;
    t_red_ctl              w_opd_ctl;
    t_mul_ctl              w_mul_ctl;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !(r_out_valid && i_out_stall);
    assign w_finish    = (r_state == S_DONE) && w_out_free;

    // Magnitude of the operand; the most negative word maps onto itself,
    // which is exactly its magnitude read as unsigned.
    assign w_mag = i_operand[WORD_BITS-1] ? (~i_operand + 1'b1) : i_operand;

    // Serial remainder units: one for the stored accumulator, which may
    // exceed a newly lowered modulus, and one for the operand magnitude.
    always_comb begin
        w_acc_ctl.clear = w_accept;
        w_acc_ctl.step  = (r_state == S_RED);
        w_acc_ctl.din   = r_acc_sh[SER_BITS-1];
        w_opd_ctl.clear = w_accept;
        w_opd_ctl.step  = (r_state == S_RED);
        w_opd_ctl.din   = r_opd_sh[SER_BITS-1];
        w_mul_ctl.start = (r_state == S_ADJ);
        w_mul_ctl.step  = (r_state == S_MUL);
    end

    maalu_reduce u_acc_red (
        .i_clk (i_clk),
        .i_ctl (w_acc_ctl),
        .i_mod (r_mod),
        .o_rem (w_acc_rem)
    );

    maalu_reduce u_opd_red (
        .i_clk (i_clk),
        .i_ctl (w_opd_ctl),
        .i_mod (r_mod),
        .o_rem (w_opd_rem)
    );

    // A negative operand with a nonzero remainder becomes m minus it.
    assign w_op_adj = (r_neg && (w_opd_rem != '0)) ? (r_mod - w_opd_rem) : w_opd_rem;

    maalu_mul u_mul (
        .i_clk    (i_clk),
        .i_ctl    (w_mul_ctl),
        .i_mplier (w_op_adj),
        .i_mcand  (w_acc_rem),
        .i_mod    (r_mod),
        .o_prod   (w_prod)
    );

    // Load, add and subtract (multiply passes the product). The subtract picks a - r or a + m - r, both
    // formed side by side, by comparing a with r.
    always_comb begin
        w_add     = {1'b0, w_acc_rem} + {1'b0, r_op};
        w_add_sub = w_add - {1'b0, r_mod};
        case (r_cmd)
            CMD_LOAD: begin
                w_alu = r_op;
            end
            CMD_ADD: begin
                w_alu = (w_add >= {1'b0, r_mod}) ? w_add_sub[RES_W-1:0] : w_add[RES_W-1:0];
            end
            CMD_SUB: begin
                w_alu = (w_acc_rem >= r_op) ? (w_acc_rem - r_op)
                                            : (w_acc_rem + (r_mod - r_op));
            end
            default: begin
                w_alu = w_prod;
            end
        endcase
    end

    assign w_final = (r_cmd == CMD_MUL) ? w_prod : r_res;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RED;
                    n_cnt   = CNT_W'(SER_BITS - 1);
                end
            end
            S_RED: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_ADJ;
                end
            end
            S_ADJ: begin
                if (r_cmd == CMD_MUL) begin
                    n_state = S_MUL;
                    n_cnt   = CNT_W'(MUL_STEPS - 1);
                end else begin
                    n_state = S_ALU;
                end
            end
            S_ALU: begin
                n_state = S_DONE;
            end
            S_MUL: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and the architectural registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cfg_mod   <= MOD_RESET;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_mod <= i_cfg_modulus;
            end
            if (w_finish) begin
                r_acc <= w_final;
            end
            r_out_valid <= !w_out_free || w_finish;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            // Modulus zero behaves as modulus one.
            r_mod    <= (r_cfg_mod == '0) ? RES_W'(1) : r_cfg_mod;
            r_cmd    <= t_cmd'(i_cmd);
            r_neg    <= i_operand[WORD_BITS-1];
            r_acc_sh <= SER_BITS'(r_acc);
            r_opd_sh <= SER_BITS'(w_mag);
        end else if (r_state == S_RED) begin
            r_acc_sh <= {r_acc_sh[SER_BITS-2:0], 1'b0};
            r_opd_sh <= {r_opd_sh[SER_BITS-2:0], 1'b0};
        end
        if (r_state == S_ADJ) begin
            r_op <= w_op_adj;
        end
        if (r_state == S_ALU) begin
            r_res <= w_alu;
        end
        if (w_finish) begin
            r_residue <= w_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_residue   = r_residue;

endmodule

`default_nettype wire

// File: sv/maalu_reduce.sv
// ============================================================================
// maalu_reduce: bit-serial remainder unit
// Takes a number MSB first, one bit per step, and keeps its remainder mod m.
// ============================================================================
`default_nettype none

module maalu_reduce
    import maalu_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_red_ctl         i_ctl,
    input  wire logic [RES_W-1:0] i_mod,
    output logic      [RES_W-1:0] o_rem
);

    logic [RES_W-1:0] r_rem;
    logic [RES_W-1:0] n_rem;
    logic [RES_W:0]   w_shift;
    logic [RES_W:0]   w_diff;

    // The remainder stays below m, so twice it plus one bit stays below 2m
    // and a single conditional subtract brings it back into range.
    always_comb begin
        w_shift = {r_rem, i_ctl.din};
        w_diff  = w_shift - {1'b0, i_mod};
        n_rem   = r_rem;
        if (i_ctl.clear) begin
            n_rem = '0;
        end else if (i_ctl.step) begin
            if (w_shift >= {1'b0, i_mod}) begin
                n_rem = w_diff[RES_W-1:0];
            end else begin
                n_rem = w_shift[RES_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire

// File: sv/maalu_mul.sv
// ============================================================================
// maalu_mul: bit-serial modular multiplier
// Double-and-add over the multiplier bits, MSB first, one bit per cycle.
// ============================================================================
`default_nettype none

module maalu_mul
    import maalu_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_mul_ctl         i_ctl,
    input  wire logic [RES_W-1:0] i_mplier,
    input  wire logic [RES_W-1:0] i_mcand,
    input  wire logic [RES_W-1:0] i_mod,
    output logic      [RES_W-1:0] o_prod
);

    logic [RES_W-1:0] r_prod;
    logic [RES_W-1:0] n_prod;
    logic [RES_W-1:0] r_mplier;
    logic [RES_W-1:0] n_mplier;
    logic [RES_W+1:0] w_sum;
    logic [RES_W+1:0] w_mod1;
    logic [RES_W+1:0] w_mod2;
    logic [RES_W+1:0] w_sub1;
    logic [RES_W+1:0] w_sub2;

    // Both the product and the multiplicand are below m, so 2p + a is below
    // 3m; subtracting m or 2m, chosen by two parallel compares, reduces it.
    always_comb begin
        w_mod1   = {2'b00, i_mod};
        w_mod2   = {1'b0, i_mod, 1'b0};
        w_sum    = {1'b0, r_prod, 1'b0}
                 + (r_mplier[RES_W-1] ? {2'b00, i_mcand} : '0);
        w_sub1   = w_sum - w_mod1;
        w_sub2   = w_sum - w_mod2;
        n_prod   = r_prod;
        n_mplier = r_mplier;
        if (i_ctl.start) begin
            n_prod   = '0;
            n_mplier = i_mplier;
        end else if (i_ctl.step) begin
            n_mplier = {r_mplier[RES_W-2:0], 1'b0};
            if (w_sum >= w_mod2) begin
                n_prod = w_sub2[RES_W-1:0];
            end else if (w_sum >= w_mod1) begin
                n_prod = w_sub1[RES_W-1:0];
            end else begin
                n_prod = w_sum[RES_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_mplier <= n_mplier;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire
